// ===== sv/xor_parity_fec_encoder_core_defines.svh =====
// assertion macros used by the encoder core
`ifndef XOR_PARITY_FEC_ENCODER_CORE_DEFINES_SVH
`define XOR_PARITY_FEC_ENCODER_CORE_DEFINES_SVH

// checked only while reset is released
`define XPF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define XPF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/xpf_pkg.sv =====
`default_nettype none

package xpf_pkg;

    // default geometry of the history ring
    localparam int unsigned HISTORY_FRAMES_DEF = 8;
    localparam int unsigned PAYLOAD_BYTES_DEF  = 160;

    // field widths
    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned BYTE_W = 8;

    // distance back to the two protected frames
    localparam int unsigned BACK_NEAR = 1;
    localparam int unsigned BACK_FAR  = 3;

    // one input item
    typedef struct packed {
        logic [SEQ_W-1:0]  frame_seq;
        logic [POS_W-1:0]  byte_pos;
        logic [BYTE_W-1:0] payload_byte;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [SEQ_W-1:0]  out_seq;
        logic [POS_W-1:0]  out_pos;
        logic [BYTE_W-1:0] data_out;
        logic [BYTE_W-1:0] parity_out;
        logic              frame_end;
    } t_out_item;

    // stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_load;

    // status from the history block
    typedef struct packed {
        logic clearing;
    } t_hist_status;

endpackage

`default_nettype wire

// ===== sv/xpf_stream_if.sv =====
`default_nettype none

// input channel
interface xpf_in_if;
    import xpf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// output channel
interface xpf_out_if;
    import xpf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/xpf_ram.sv =====
`default_nettype none

module xpf_ram #(
    parameter int unsigned WIDTH = xpf_pkg::BYTE_W,
    parameter int unsigned DEPTH = xpf_pkg::HISTORY_FRAMES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports, held while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== sv/xpf_slot_calc.sv =====
`default_nettype none

module xpf_slot_calc #(
    parameter int unsigned HISTORY_FRAMES = xpf_pkg::HISTORY_FRAMES_DEF
) (
    input  logic                              i_clk,
    input  xpf_pkg::t_pipe_load               i_load,
    input  logic [xpf_pkg::SEQ_W-1:0]         i_seq,
    output logic [$clog2(HISTORY_FRAMES)-1:0] o_slot
);
    import xpf_pkg::*;

    localparam int unsigned SLOT_W = $clog2(HISTORY_FRAMES);
    localparam int unsigned REM_W  = SLOT_W + 1;
    localparam int unsigned PROD_W = 2 * SEQ_W;
    // floor(2^32 / frames): quotient estimate is exact or one short
    localparam logic [PROD_W-1:0] RECIP_WIDE = (PROD_W'(1) << SEQ_W) / HISTORY_FRAMES;
    localparam logic [SEQ_W-1:0]  RECIP      = RECIP_WIDE[SEQ_W-1:0];
    localparam logic [REM_W-1:0]  DIV_R      = REM_W'(HISTORY_FRAMES);

    logic [PROD_W-1:0] w_prod;
    logic [SEQ_W-1:0]  r_quot;
    logic [REM_W-1:0]  r_seq_lo;
    logic [REM_W-1:0]  w_quot_x;
    logic [REM_W-1:0]  w_rem;
    logic [REM_W-1:0]  w_rem_fix;
    logic [SLOT_W-1:0] r_slot;

    // stage 1: quotient estimate by reciprocal multiply
    assign w_prod = PROD_W'(i_seq) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load.s1) begin
            r_quot   <= w_prod[PROD_W-1:SEQ_W];
            r_seq_lo <= i_seq[REM_W-1:0];
        end
    end

    // stage 2: remainder is below twice the ring size, so only low bits matter
    assign w_quot_x  = r_quot[REM_W-1:0] * DIV_R;
    assign w_rem     = r_seq_lo - w_quot_x;
    assign w_rem_fix = (w_rem >= DIV_R) ? (w_rem - DIV_R) : w_rem;

    always_ff @(posedge i_clk) begin
        if (i_load.s2) begin
            r_slot <= w_rem_fix[SLOT_W-1:0];
        end
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

// ===== sv/xpf_history.sv =====
`default_nettype none

module xpf_history #(
    parameter int unsigned HISTORY_FRAMES = xpf_pkg::HISTORY_FRAMES_DEF,
    parameter int unsigned PAYLOAD_BYTES  = xpf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  xpf_pkg::t_pipe_load               i_load,
    input  logic                              i_issue,
    input  logic [$clog2(HISTORY_FRAMES)-1:0] i_slot,
    input  xpf_pkg::t_in_item                 i_item,
    input  xpf_pkg::t_in_item                 i_s3_item,
    output logic [xpf_pkg::BYTE_W-1:0]        o_parity,
    output xpf_pkg::t_hist_status             o_status
);
    import xpf_pkg::*;

    localparam int unsigned SLOT_W = $clog2(HISTORY_FRAMES);
    localparam int unsigned DEPTH  = HISTORY_FRAMES * PAYLOAD_BYTES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned TAG_W  = SEQ_W + 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_FRAMES - 1);
    localparam logic [SLOT_W-1:0] NEAR_STEP = SLOT_W'(BACK_NEAR);
    localparam logic [SLOT_W-1:0] FAR_STEP  = SLOT_W'(BACK_FAR);
    localparam logic [SLOT_W-1:0] FAR_WRAP  = SLOT_W'(HISTORY_FRAMES - BACK_FAR);
    localparam logic [ADDR_W-1:0] ROW_LEN   = ADDR_W'(PAYLOAD_BYTES);
    localparam logic [SEQ_W-1:0]  SEQ_NEAR  = SEQ_W'(BACK_NEAR);
    localparam logic [SEQ_W-1:0]  SEQ_FAR   = SEQ_W'(BACK_FAR);

    logic              r_clr_busy;
    logic              n_clr_busy;
    logic [SLOT_W-1:0] r_clr_idx;
    logic [SLOT_W-1:0] n_clr_idx;

    logic              w_in_range;
    logic [SLOT_W-1:0] w_slot_near;
    logic [SLOT_W-1:0] w_slot_far;
    logic [ADDR_W-1:0] w_addr_own;
    logic [ADDR_W-1:0] w_addr_near;
    logic [ADDR_W-1:0] w_addr_far;
    logic              w_store;

    logic              w_tag_we;
    logic [SLOT_W-1:0] w_tag_waddr;
    logic [TAG_W-1:0]  w_tag_wdata;
    logic [TAG_W-1:0]  w_tag_near;
    logic [TAG_W-1:0]  w_tag_far;
    logic [BYTE_W-1:0] w_byte_near;
    logic [BYTE_W-1:0] w_byte_far;

    logic              w_s3_in_range;
    logic              w_hit_near;
    logic              w_hit_far;

    // tag clearing sweep after reset, one slot a cycle
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_idx  = r_clr_idx;
        if (r_clr_busy) begin
            n_clr_idx = r_clr_idx + SLOT_W'(1);
            if (r_clr_idx == LAST_SLOT) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_idx  <= n_clr_idx;
        end
    end

    assign o_status.clearing = r_clr_busy;

    // slots of the two protected frames, wrapping around the ring
    assign w_slot_near = (i_slot == '0) ? LAST_SLOT : (i_slot - NEAR_STEP);
    assign w_slot_far  = (i_slot >= FAR_STEP) ? (i_slot - FAR_STEP) : (i_slot + FAR_WRAP);

    // byte addresses: slot row plus position
    assign w_addr_own  = ADDR_W'(i_slot) * ROW_LEN + ADDR_W'(i_item.byte_pos);
    assign w_addr_near = ADDR_W'(w_slot_near) * ROW_LEN + ADDR_W'(i_item.byte_pos);
    assign w_addr_far  = ADDR_W'(w_slot_far) * ROW_LEN + ADDR_W'(i_item.byte_pos);

    assign w_in_range = (32'(i_item.byte_pos) < PAYLOAD_BYTES);
    assign w_store    = i_issue && w_in_range;

    // tag port: sweep has priority, otherwise the item retags its own slot
    assign w_tag_we    = r_clr_busy || w_store;
    assign w_tag_waddr = r_clr_busy ? r_clr_idx : i_slot;
    assign w_tag_wdata = r_clr_busy ? '0 : {1'b1, i_item.frame_seq};

    xpf_ram #(
        .WIDTH (TAG_W),
        .DEPTH (HISTORY_FRAMES)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_we      (w_tag_we),
        .i_waddr   (w_tag_waddr),
        .i_wdata   (w_tag_wdata),
        .i_re      (i_load.s3),
        .i_raddr_a (w_slot_near),
        .i_raddr_b (w_slot_far),
        .o_rdata_a (w_tag_near),
        .o_rdata_b (w_tag_far)
    );

    xpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_we      (w_store),
        .i_waddr   (w_addr_own),
        .i_wdata   (i_item.payload_byte),
        .i_re      (i_load.s3),
        .i_raddr_a (w_addr_near),
        .i_raddr_b (w_addr_far),
        .o_rdata_a (w_byte_near),
        .o_rdata_b (w_byte_far)
    );

    // frame presence: valid mark set and tag equal to the wanted number
    assign w_s3_in_range = (32'(i_s3_item.byte_pos) < PAYLOAD_BYTES);
    assign w_hit_near = (i_s3_item.frame_seq >= SEQ_NEAR) && w_tag_near[TAG_W-1]
                     && (w_tag_near[SEQ_W-1:0] == (i_s3_item.frame_seq - SEQ_NEAR));
    assign w_hit_far  = (i_s3_item.frame_seq >= SEQ_FAR) && w_tag_far[TAG_W-1]
                     && (w_tag_far[SEQ_W-1:0] == (i_s3_item.frame_seq - SEQ_FAR));

    // parity of the protected bytes, absent frames count as zero, a position past the payload gives zero
    always_comb begin
        o_parity = '0;
        if (w_s3_in_range) begin
            o_parity = (w_hit_near ? w_byte_near : '0) ^ (w_hit_far ? w_byte_far : '0);
        end
    end

endmodule

`default_nettype wire

// ===== sv/xor_parity_fec_encoder_core.sv =====
// XOR parity encoder for audio frames, one payload byte per item.
// Input channel i_in: frame sequence number, byte position, payload byte.
// Output channel o_out: the same three fields, a parity byte (same position
// of frames seq-1 and seq-3 XORed, zero where a frame is not in the ring)
// and a frame end flag on the last payload position.
// Throughput: one item per cycle while o_out.ready is high and no tag sweep
// runs. Each item inside the payload makes one write and two reads on the
// history RAM and one write and two reads on the tag RAM. An item passes
// through the input register, two slot-index stages, the RAM read stage and
// the output register.
// Reset: pipeline empties, then a sweep clears the slot tags, one slot a
// cycle; i_in.ready stays low meanwhile.
// Payload bytes are not cleared; positions never written read undefined.
// Stall: a held result stays in the output register; stages behind it keep
// filling bubbles, and ready drops only once every stage holds an item.
`default_nettype none

`include "xor_parity_fec_encoder_core_defines.svh"

module xor_parity_fec_encoder_core #(
    parameter int unsigned HISTORY_FRAMES = xpf_pkg::HISTORY_FRAMES_DEF,
    parameter int unsigned PAYLOAD_BYTES  = xpf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xpf_in_if.sink     i_in,
    xpf_out_if.source  o_out
);
    import xpf_pkg::*;

    localparam int unsigned SLOT_W = $clog2(HISTORY_FRAMES);

    logic r_v0, r_v1, r_v2, r_v3, r_vo;
    logic n_v0, n_v1, n_v2, n_v3, n_vo;

    t_in_item  r_s0_item;
    t_in_item  r_s1_item;
    t_in_item  r_s2_item;
    t_in_item  r_s3_item;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic w_load0, w_load1, w_load2, w_load3, w_load_o;
    logic w_accept;

    t_pipe_load        w_load;
    t_hist_status      w_hist_status;
    logic [SLOT_W-1:0] w_slot;
    logic [BYTE_W-1:0] w_parity;

    // stage loads: a stage takes new data when empty or when it moves on
    assign w_load_o = !r_vo || o_out.ready;
    assign w_load3  = !r_v3 || w_load_o;
    assign w_load2  = !r_v2 || w_load3;
    assign w_load1  = !r_v1 || w_load2;
    assign w_load0  = !r_v0 || w_load1;

    assign i_in.ready = w_load0 && !w_hist_status.clearing;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_load.s1 = w_load1;
    assign w_load.s2 = w_load2;
    assign w_load.s3 = w_load3;

    // valid chain
    always_comb begin
        n_v0 = w_load0  ? w_accept : r_v0;
        n_v1 = w_load1  ? r_v0     : r_v1;
        n_v2 = w_load2  ? r_v1     : r_v2;
        n_v3 = w_load3  ? r_v2     : r_v3;
        n_vo = w_load_o ? r_v3     : r_vo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_vo <= n_vo;
        end
    end

    // item fields carried down the pipeline
    always_ff @(posedge i_clk) begin
        if (w_load0) begin
            r_s0_item <= i_in.data;
        end
        if (w_load1) begin
            r_s1_item <= r_s0_item;
        end
        if (w_load2) begin
            r_s2_item <= r_s1_item;
        end
        if (w_load3) begin
            r_s3_item <= r_s2_item;
        end
    end

    // ring slot of the frame
    xpf_slot_calc #(
        .HISTORY_FRAMES (HISTORY_FRAMES)
    ) u_slot_calc (
        .i_clk  (i_clk),
        .i_load (w_load),
        .i_seq  (r_s0_item.frame_seq),
        .o_slot (w_slot)
    );

    // history store, tag lookup and parity
    xpf_history #(
        .HISTORY_FRAMES (HISTORY_FRAMES),
        .PAYLOAD_BYTES  (PAYLOAD_BYTES)
    ) u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_issue   (w_load3 && r_v2),
        .i_slot    (w_slot),
        .i_item    (r_s2_item),
        .i_s3_item (r_s3_item),
        .o_parity  (w_parity),
        .o_status  (w_hist_status)
    );

    // result item
    always_comb begin
        n_out_item.out_seq    = r_s3_item.frame_seq;
        n_out_item.out_pos    = r_s3_item.byte_pos;
        n_out_item.data_out   = r_s3_item.payload_byte;
        n_out_item.parity_out = w_parity;
        n_out_item.frame_end  = (32'(r_s3_item.byte_pos) == (PAYLOAD_BYTES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (w_load_o) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid = r_vo;
    assign o_out.data  = r_out_item;

    // checks
    `XPF_ASSERT_ALWAYS(a_reset_starts_clear, i_clk, !i_rst_n |=> w_hist_status.clearing, "tag sweep did not start after reset")
    `XPF_ASSERT_RST(a_no_accept_in_clear, i_clk, i_rst_n, w_hist_status.clearing |-> !i_in.ready, "input ready during tag sweep")
    `XPF_ASSERT_RST(a_accept_lands, i_clk, i_rst_n, w_accept |=> r_v0, "accepted item lost at input register")
    `XPF_ASSERT_RST(a_end_on_last, i_clk, i_rst_n, (o_out.valid && o_out.data.frame_end) |-> (32'(o_out.data.out_pos) == (PAYLOAD_BYTES - 1)), "frame end off last position")
    `XPF_ASSERT_RST(a_range_zero, i_clk, i_rst_n, (o_out.valid && (32'(o_out.data.out_pos) >= PAYLOAD_BYTES)) |-> (o_out.data.parity_out == '0), "parity on out of range position")
    `XPF_ASSERT_RST(a_first_frame_zero, i_clk, i_rst_n, (o_out.valid && (o_out.data.out_seq == '0)) |-> (o_out.data.parity_out == '0), "parity on frame zero")

endmodule

`default_nettype wire

// ===== tb/sv/xpf_parity_monitor.sv =====
// watches both channels, predicts each encoded byte and compares results
module xpf_parity_monitor #(
    parameter int unsigned HISTORY_FRAMES = xpf_pkg::HISTORY_FRAMES_DEF,
    parameter int unsigned PAYLOAD_BYTES  = xpf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    xpf_in_if    i_in,
    xpf_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import xpf_pkg::*;

    // predicted copy of the frame history ring
    logic [BYTE_W-1:0] ring_bytes [HISTORY_FRAMES][PAYLOAD_BYTES];
    logic [SEQ_W-1:0]  ring_tag   [HISTORY_FRAMES];
    bit                ring_held  [HISTORY_FRAMES];

    // encoded bytes still owed by the block, oldest first
    t_out_item awaited_bytes [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        foreach (ring_held[s]) ring_held[s] = 1'b0;
    end

    // byte at pos of frame seq-back, zero when that frame is not in the ring
    function automatic logic [BYTE_W-1:0] byte_back(input logic [SEQ_W-1:0] seq,
                                                    input int unsigned back,
                                                    input logic [POS_W-1:0] pos);
        logic [SEQ_W-1:0] want;
        int unsigned      slot;
        if (seq < back) return '0;
        want = seq - back;
        slot = want % HISTORY_FRAMES;
        if (!ring_held[slot] || ring_tag[slot] != want) return '0;
        return ring_bytes[slot][pos];
    endfunction

    // parity of one payload byte, then store it in the ring
    function automatic t_out_item encode_byte(input t_in_item it);
        t_out_item   r;
        int unsigned slot;
        r.out_seq    = it.frame_seq;
        r.out_pos    = it.byte_pos;
        r.data_out   = it.payload_byte;
        r.parity_out = '0;
        r.frame_end  = 1'b0;
        if (it.byte_pos < PAYLOAD_BYTES) begin
            slot = it.frame_seq % HISTORY_FRAMES;
            r.parity_out = byte_back(it.frame_seq, BACK_NEAR, it.byte_pos)
                         ^ byte_back(it.frame_seq, BACK_FAR, it.byte_pos);
            // first byte of a new frame retakes the slot, old bytes stay
            if (!ring_held[slot] || ring_tag[slot] != it.frame_seq) begin
                ring_tag[slot]  = it.frame_seq;
                ring_held[slot] = 1'b1;
            end
            ring_bytes[slot][it.byte_pos] = it.payload_byte;
            r.frame_end = (it.byte_pos == PAYLOAD_BYTES - 1);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [SEQ_W-1:0] want_v,
                                 input logic [SEQ_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (ring_held[s]) ring_held[s] = 1'b0;
            awaited_bytes.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                awaited_bytes.push_back(encode_byte(i_in.data));
            end
            if (i_out.valid && i_out.ready) begin
                if (awaited_bytes.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %0h",
                             $time, i_out.data);
                    o_fail_count++;
                end else begin
                    want = awaited_bytes.pop_front();
                    compare_field("out_seq", want.out_seq, i_out.data.out_seq);
                    compare_field("out_pos", SEQ_W'(want.out_pos),
                                  SEQ_W'(i_out.data.out_pos));
                    compare_field("data_out", SEQ_W'(want.data_out),
                                  SEQ_W'(i_out.data.data_out));
                    compare_field("parity_out", SEQ_W'(want.parity_out),
                                  SEQ_W'(i_out.data.parity_out));
                    compare_field("frame_end", SEQ_W'(want.frame_end),
                                  SEQ_W'(i_out.data.frame_end));
                    o_checked++;
                end
            end
        end
        o_pending = awaited_bytes.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// stimulus, handshake pacing and verdict for the parity encoder
module tb;
    import xpf_pkg::*;

    localparam int unsigned RING        = HISTORY_FRAMES_DEF;
    localparam int unsigned PAYLOAD     = PAYLOAD_BYTES_DEF;
    localparam int          ITEM_TARGET = 850;
    localparam int          HOLD_CYCLES = 200;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    xpf_in_if  in_ch ();
    xpf_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;

    xor_parity_fec_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    xpf_parity_monitor parity_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 i_clk = ~i_clk;

    // pacing controls for sender and receiver
    bit tx_steady;
    bit rx_steady;
    bit hold_req;

    // which ring positions the block has stored since reset
    logic [SEQ_W-1:0] sent_tag     [RING];
    bit               sent_held    [RING];
    bit               sent_written [RING][PAYLOAD];

    int               items_sent;
    int               outside_sent;
    int               retakes;
    logic [SEQ_W-1:0] stream_next;

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int tx_gap();
        if (tx_steady || $urandom_range(0, 99) < 60) return 0;
        return pick_gap();
    endfunction

    // false when seq-back is held but its byte at pos was never stored
    function automatic bit back_defined(input logic [SEQ_W-1:0] seq, input int unsigned back,
                                        input int unsigned pos);
        logic [SEQ_W-1:0] want;
        int unsigned      slot;
        if (seq < back) return 1'b1;
        want = seq - back;
        slot = want % RING;
        return !(sent_held[slot] && sent_tag[slot] == want && !sent_written[slot][pos]);
    endfunction

    // move a position whose parity would read an unstored byte
    function automatic logic [POS_W-1:0] defined_pos(input logic [SEQ_W-1:0] seq,
                                                     input logic [POS_W-1:0] pos);
        int unsigned start;
        int unsigned p;
        if (pos >= PAYLOAD) return pos;
        if (back_defined(seq, BACK_NEAR, 32'(pos)) && back_defined(seq, BACK_FAR, 32'(pos))) begin
            return pos;
        end
        start = $urandom_range(0, PAYLOAD - 1);
        for (int k = 0; k < PAYLOAD; k++) begin
            p = (start + k) % PAYLOAD;
            if (back_defined(seq, BACK_NEAR, p) && back_defined(seq, BACK_FAR, p)) begin
                return POS_W'(p);
            end
        end
        return POS_W'($urandom_range(PAYLOAD, 255));
    endfunction

    // offer one item after gap idle cycles and wait until it is taken
    task automatic send_item(input logic [SEQ_W-1:0] seq, input logic [POS_W-1:0] pos,
                             input logic [BYTE_W-1:0] data, input int gap);
        t_in_item    it;
        int unsigned slot;
        it.frame_seq    = seq;
        it.byte_pos     = defined_pos(seq, pos);
        it.payload_byte = data;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (it.byte_pos >= PAYLOAD) begin
            outside_sent++;
        end else begin
            slot = seq % RING;
            if (!sent_held[slot] || sent_tag[slot] != seq) begin
                sent_tag[slot]  = seq;
                sent_held[slot] = 1'b1;
                retakes++;
            end
            sent_written[slot][it.byte_pos] = 1'b1;
        end
    endtask

    // sender pauses until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // consecutive frames sharing one set of positions, with some breakage
    task automatic send_run();
        logic [SEQ_W-1:0]  base;
        logic [SEQ_W-1:0]  f_seq;
        logic [POS_W-1:0]  plan  [$];
        logic [POS_W-1:0]  order [$];
        logic [POS_W-1:0]  tmp;
        int                frames;
        int                n_pos;
        int                r;
        int                j;
        bit                in_order;
        r = $urandom_range(0, 99);
        if (r < 35) base = $urandom();
        else if (r < 50) base = $urandom_range(0, 12);
        else if (r < 65) base = 32'hFFFF_FFFF - $urandom_range(0, 6);
        else base = stream_next + $urandom_range(0, RING + 1);
        frames = $urandom_range(3, 8);
        r = $urandom_range(0, 99);
        if (r < 70) n_pos = $urandom_range(1, 10);
        else if (r < 95) n_pos = $urandom_range(11, 24);
        else n_pos = $urandom_range(40, 80);
        in_order = 1'($urandom_range(0, 1));
        for (int i = 0; i < n_pos; i++) begin
            plan.push_back(in_order ? POS_W'(i) : POS_W'($urandom_range(0, PAYLOAD - 1)));
        end
        if ($urandom_range(0, 99) < 30) plan.push_back(POS_W'(PAYLOAD - 1));
        f_seq = base;
        for (int f = 0; f < frames; f++) begin
            r = $urandom_range(0, 99);
            // skipped frame or repeated frame
            if (r < 8) f_seq = f_seq + 1;
            else if (r < 12 && f > 0) f_seq = f_seq - 1;
            order = plan;
            if ($urandom_range(0, 99) < 20) begin
                for (int i = order.size() - 1; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
            end
            if (order.size() > 1 && $urandom_range(0, 99) < 15) begin
                order.delete($urandom_range(0, order.size() - 1));
            end
            // stop near the item budget
            foreach (order[i]) begin
                if (items_sent < ITEM_TARGET) begin
                    send_item(f_seq, order[i], BYTE_W'($urandom_range(0, 255)), tx_gap());
                end
            end
            f_seq = f_seq + 1;
        end
        stream_next = f_seq;
    endtask

    // unrelated bytes, positions past the payload included
    task automatic send_noise();
        logic [SEQ_W-1:0] seq;
        int               n;
        n = $urandom_range(3, 15);
        repeat (n) begin
            seq = $urandom_range(0, 1) ? $urandom() : stream_next - $urandom_range(0, 4);
            send_item(seq, POS_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                      tx_gap());
        end
    endtask

    // receiver: random stalls, steady stretches and one long hold
    initial begin : receiver
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
                out_ch.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[xor_parity_fec_encoder_core] ERROR");
        $finish;
    end

    initial begin : stimulus
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_req     = 1'b0;
        items_sent   = 0;
        outside_sent = 0;
        retakes      = 0;
        stream_next  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // low sequence numbers, last position, slot retake, wrap of the number
        send_item(32'd0, 8'd0, 8'hFF, 0);
        send_item(32'd0, 8'd159, 8'h96, 0);
        send_item(32'd1, 8'd0, 8'hA5, 0);
        send_item(32'd1, 8'd159, 8'h5A, 0);
        send_item(32'd2, 8'd0, 8'h3C, 0);
        send_item(32'd2, 8'd159, 8'hC3, 0);
        send_item(32'd3, 8'd0, 8'h81, 0);
        send_item(32'd3, 8'd159, 8'h00, 0);
        send_item(32'd4, 8'd0, 8'h7E, 0);
        send_item(32'd5, 8'd160, 8'hFF, 0);
        send_item(32'd5, 8'd255, 8'h00, 0);
        send_item(32'd8, 8'd0, 8'h11, 0);
        send_item(32'd9, 8'd159, 8'h22, 0);
        send_item(32'd11, 8'd0, 8'h33, 0);
        send_item(32'hFFFF_FFFF, 8'd0, 8'h44, 0);
        send_item(32'd0, 8'd0, 8'h55, 0);
        send_item(32'd1, 8'd0, 8'h66, 0);
        send_item(32'hFFFF_FFFF, 8'd159, 8'h77, 0);
        send_item(32'd2, 8'd0, 8'h88, 0);
        send_item(32'h8000_0000, 8'd127, 8'h99, 0);
        send_item(32'h7FFF_FFFF, 8'd128, 8'hAA, 0);
        send_item(32'd3, 8'd0, 8'hBB, 0);
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_req = 1'b1;
        for (int k = 0; k < 48; k++) begin
            send_item(SEQ_W'(20 + k / 8), POS_W'(k % 8), BYTE_W'($urandom_range(0, 255)), 0);
        end
        wait_drained();
        stream_next = 32'd26;

        // random runs of frames with some noise
        while (items_sent < ITEM_TARGET) begin
            tx_steady = ($urandom_range(0, 99) < 20);
            rx_steady = ($urandom_range(0, 99) < 20);
            if ($urandom_range(0, 99) < 15) send_noise();
            else send_run();
            if ($urandom_range(0, 99) < 10) wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d items (%0d past the payload end), %0d results compared",
                 items_sent, outside_sent, checked);
        $display("ring slots taken over %0d times, with a long output hold and full drains",
                 retakes);
        if (fail_count == 0 && pending == 0) begin
            $display("[xor_parity_fec_encoder_core] OK");
        end else begin
            $display("[xor_parity_fec_encoder_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/xpf_pkg.sv
sv/xpf_stream_if.sv
sv/xpf_ram.sv
sv/xpf_slot_calc.sv
sv/xpf_history.sv
sv/xor_parity_fec_encoder_core.sv
tb/sv/xpf_parity_monitor.sv
tb/sv/tb.sv
